// ----- rtl/core/pocsag_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pocsag_pkg
// Shared types, constants and coding functions of the POCSAG paging encoder.
// ============================================================================
package pocsag_pkg;

    // Codeword slots in one batch, and the slot counter width.
    localparam int SLOTS_PER_BATCH = 16;
    localparam int SLOT_W          = $clog2(SLOTS_PER_BATCH);

    // Fixed transmit words.
    localparam logic [31:0] SYNC_WORD        = 32'h7CD2_15D8;
    localparam logic [31:0] IDLE_WORD        = 32'h7A89_C197;
    localparam logic [31:0] PREAMBLE_PATTERN = 32'hAAAA_AAAA;

    // BCH(31,21) generator polynomial.
    localparam logic [10:0] BCH_GEN = 11'h769;

    // Message bits per codeword and per character.
    localparam int          MSG_BITS = 20;
    localparam logic [2:0]  ALPHA_W  = 3'd7;
    localparam logic [2:0]  NUM_W    = 3'd4;

    // End-of-message fill, already laid out in send order (first bit is the MSB).
    // Alpha repeats EOT (0x04, seven bits); numeric repeats space (0xC, four bits).
    localparam logic [19:0] PAD_ALPHA = 20'h20408;
    localparam logic [19:0] PAD_NUM   = 20'h33333;

    // Message kinds; any kind other than tone or alpha is sent as numeric.
    localparam logic [1:0] KIND_TONE  = 2'd0;
    localparam logic [1:0] KIND_NUM   = 2'd1;
    localparam logic [1:0] KIND_ALPHA = 2'd2;

    // Depth of the command queue between the front and the back end.
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Input item opcodes.
    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_CHAR  = 2'd1,
        OP_END   = 2'd2
    } t_opcode;

    // Commands handed from the front to the back end.
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_MSG   = 2'd1,
        CMD_END   = 2'd2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op              op;
        logic [20:0]          info;    // codeword bits 31..11 before BCH
        logic                 has_cw;  // end command carries a final message codeword
        logic [SLOT_W-1:0]    target;  // slot of the address codeword
        logic [3:0]           tail;    // extra idles after the terminating idle
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_push;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        BK_IDLE  = 3'd0,
        BK_PRE   = 3'd1,
        BK_PAD_S = 3'd2,
        BK_CW    = 3'd3,
        BK_TAIL  = 3'd4,
        BK_PAD_E = 3'd5
    } t_bk_state;

    // Parity-check contribution of codeword bit j (a constant for each j).
    function automatic logic [9:0] bch_col(input int j);
        logic [31:0] rem;
        rem = 32'd1 << j;
        for (int i = 31; i >= 11; i--) begin
            if (rem[i]) begin
                rem = rem ^ (32'(BCH_GEN) << (i - 10));
            end
        end
        return rem[10:1];
    endfunction

    // Full codeword: 21 info bits, 10 check bits, even parity.
    function automatic logic [31:0] bch_encode(input logic [20:0] info);
        logic [9:0]  rem;
        logic [31:0] cw;
        rem = '0;
        for (int j = 0; j < 21; j++) begin
            if (info[j]) begin
                rem = rem ^ bch_col(j + 11);
            end
        end
        cw    = {info, rem, 1'b0};
        cw[0] = ^cw;
        return cw;
    endfunction

    // Byte to 4-bit numeric code; unknown bytes become a space.
    function automatic logic [3:0] numeric_code(input logic [7:0] c);
        logic [3:0] code;
        if (c >= 8'h30 && c <= 8'h39) begin
            code = 4'(c - 8'h30);
        end else begin
            case (c)
                8'h2A:        code = 4'd10;  // '*'
                8'h55, 8'h75: code = 4'd11;  // 'U' or 'u'
                8'h20:        code = 4'd12;  // ' '
                8'h2D:        code = 4'd13;  // '-'
                8'h29:        code = 4'd14;  // ')'
                8'h28:        code = 4'd15;  // '('
                default:      code = 4'd12;
            endcase
        end
        return code;
    endfunction

    // Bit reversal, so that the first bit sent lands in the MSB.
    function automatic logic [6:0] rev7(input logic [6:0] v);
        logic [6:0] r;
        for (int i = 0; i < 7; i++) begin
            r[i] = v[6-i];
        end
        return r;
    endfunction

    function automatic logic [3:0] rev4(input logic [3:0] v);
        logic [3:0] r;
        for (int i = 0; i < 4; i++) begin
            r[i] = v[3-i];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/pocsag_paging_encoder.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pocsag_paging_encoder
// POCSAG transmit encoder: message items in, 32-bit transmit words out.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes start, character and end items.
//   Output channel (o_out_valid / i_out_stall) gives 32-bit words, MSB sent first,
//   with o_last_of_run on the last word caused by an input item and o_transmission_done
//   on the final word of a message. i_cfg_we writes the tail idle count (reset
//   value 6); the user writes it only while the block idles, unchecked by the block.
// Timing:
//   The front end takes one item per cycle into a four-entry command queue;
//   it stalls only when the queue is full. The back end sequencer fetches a
//   command while idle, then sends one word per cycle unless the output stalls:
//   a character that closes a block sends its codeword, after the sync word at
//   a batch boundary. A start sends the preamble, the sync word, idles and the
//   address codeword; an end sends any final codeword, the idles and the batch fill.
//   The first word passes the command queue, sequencer state and output register.
// Reset and stall:
//   Synchronous reset empties the queue and output register and closes any
//   open message. A stall on the output holds the word and pauses the
//   sequencer; the input keeps accepting until the queue fills.
// ============================================================================
module pocsag_paging_encoder import pocsag_pkg::*; #(
    parameter int PREAMBLE_WORDS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [20:0] i_pager_address,
    input  logic [1:0]  i_function_bits,
    input  logic [1:0]  i_message_kind,
    input  logic [7:0]  i_character,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_word,
    output logic        o_last_of_run,
    output logic        o_transmission_done
);

    t_cmd_push q_push;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    t_cmd      q_head;

    // Item intake and character packing.
    pocsag_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_pager_address (i_pager_address),
        .i_function_bits (i_function_bits),
        .i_message_kind  (i_message_kind),
        .i_character     (i_character),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_q_full        (q_full),
        .o_push          (q_push)
    );

    // Command queue.
    pocsag_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Word sequencer.
    pocsag_back #(
        .PREAMBLE_WORDS (PREAMBLE_WORDS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_empty             (q_empty),
        .i_head              (q_head),
        .o_pop               (q_pop),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_word              (o_word),
        .o_last_of_run       (o_last_of_run),
        .o_transmission_done (o_transmission_done)
    );

endmodule

// ----- rtl/core/pocsag_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pocsag_front
// Accepts message items, packs characters into 20-bit message blocks and
// issues start, message and end commands to the back end.
// ============================================================================
module pocsag_front import pocsag_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [20:0] i_pager_address,
    input  logic [1:0]  i_function_bits,
    input  logic [1:0]  i_message_kind,
    input  logic [7:0]  i_character,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_q_full,
    output t_cmd_push   o_push
);

    logic [3:0]  r_tail, n_tail;
    logic [19:0] r_acc, n_acc;
    logic [4:0]  r_held, n_held;
    logic [1:0]  r_kind, n_kind;
    logic        r_open, n_open;

    logic        accept;
    logic        is_alpha;
    logic [2:0]  ch_w;
    logic [6:0]  ch_bits;
    logic [26:0] wide;
    logic [4:0]  tot;
    logic [2:0]  sh;
    logic [19:0] cw_data;
    logic [19:0] rest;
    logic [4:0]  pad_n;
    logic [19:0] pad_pat;
    logic [19:0] acc_sh;
    logic [19:0] pad_sh;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    // Character packing: append the reversed code, split off a full block.
    always_comb begin
        is_alpha = (r_kind == KIND_ALPHA);
        ch_w     = is_alpha ? ALPHA_W : NUM_W;
        ch_bits  = is_alpha ? rev7(i_character[6:0])
                            : {3'b000, rev4(numeric_code(i_character))};
        wide     = ({7'b0, r_acc} << ch_w) | {20'b0, ch_bits};
        tot      = r_held + {2'b00, ch_w};
        sh       = 3'(tot - 5'(MSG_BITS));
        cw_data  = 20'(wide >> sh);
        rest     = 20'(wide & ((27'd1 << sh) - 27'd1));
        // End of message: fill the open block with the kind's pad pattern.
        pad_n    = 5'(MSG_BITS) - r_held;
        pad_pat  = is_alpha ? PAD_ALPHA : PAD_NUM;
        acc_sh   = r_acc << pad_n;
        pad_sh   = pad_pat >> r_held;
    end

    // Item classification and message state update.
    always_comb begin
        n_tail = r_tail;
        n_acc  = r_acc;
        n_held = r_held;
        n_kind = r_kind;
        n_open = r_open;
        o_push            = '0;
        o_push.cmd.op     = CMD_MSG;
        o_push.cmd.tail   = r_tail;

        if (i_cfg_we) begin
            n_tail = i_cfg_data;
        end

        if (accept) begin
            case (t_opcode'(i_opcode))
                OP_START: begin
                    n_acc  = '0;
                    n_held = '0;
                    n_kind = i_message_kind;
                    n_open = 1'b1;
                    o_push.valid      = 1'b1;
                    o_push.cmd.op     = CMD_START;
                    o_push.cmd.info   = {1'b0, i_pager_address[20:3], i_function_bits};
                    o_push.cmd.target = {i_pager_address[2:0], 1'b0};
                end
                OP_CHAR: begin
                    if (r_open && r_kind != KIND_TONE) begin
                        if (tot >= 5'(MSG_BITS)) begin
                            n_acc  = rest;
                            n_held = {2'b00, sh};
                            o_push.valid    = 1'b1;
                            o_push.cmd.op   = CMD_MSG;
                            o_push.cmd.info = {1'b1, cw_data};
                        end else begin
                            n_acc  = 20'(wide);
                            n_held = tot;
                        end
                    end
                end
                OP_END: begin
                    if (r_open) begin
                        n_acc  = '0;
                        n_held = '0;
                        n_open = 1'b0;
                        o_push.valid      = 1'b1;
                        o_push.cmd.op     = CMD_END;
                        o_push.cmd.has_cw = (r_kind != KIND_TONE) && (r_held != 5'd0);
                        o_push.cmd.info   = {1'b1, acc_sh | pad_sh};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail <= 4'd6;
            r_acc  <= '0;
            r_held <= '0;
            r_kind <= KIND_TONE;
            r_open <= 1'b0;
        end else begin
            r_tail <= n_tail;
            r_acc  <= n_acc;
            r_held <= n_held;
            r_kind <= n_kind;
            r_open <= n_open;
        end
    end

endmodule

// ----- rtl/core/pocsag_cmdq.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pocsag_cmdq
// Short command queue that decouples the front from the back end.
// ============================================================================
module pocsag_cmdq import pocsag_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_push i_push,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_cmd      o_head
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr, r_rd;
    logic [CMDQ_CNT_W-1:0] r_cnt;
    logic                  do_push, do_pop;

    assign o_full  = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/core/pocsag_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pocsag_back
// Expands commands into transmit words, one per cycle unless stalled,
// tracking the batch slot and inserting the sync word at every batch start.
// ============================================================================
module pocsag_back import pocsag_pkg::*; #(
    parameter int PREAMBLE_WORDS = 18
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_word,
    output logic        o_last_of_run,
    output logic        o_transmission_done
);

    localparam int CNT_W = (PREAMBLE_WORDS > 16) ? $clog2(PREAMBLE_WORDS) : 4;

    t_bk_state         r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic              r_sync_sent, n_sync_sent;
    t_cmd              r_cmd, n_cmd;

    logic              r_out_valid;
    logic [31:0]       r_word;
    logic              r_last;
    logic              r_done;

    logic              adv;
    logic              is_sync;
    logic [SLOT_W-1:0] slot_inc;
    logic [31:0]       info_cw;
    logic              emit_valid;
    logic [31:0]       emit_word;
    logic              emit_last;
    logic              emit_done;

    assign adv      = !r_out_valid || !i_out_stall;
    assign is_sync  = (r_slot == '0) && !r_sync_sent;
    assign slot_inc = r_slot + 1'b1;
    assign info_cw  = bch_encode(r_cmd.info);

    // Sequencer: next state and the word offered this cycle.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_sync_sent = r_sync_sent;
        n_cmd       = r_cmd;
        o_pop       = 1'b0;
        emit_valid  = 1'b0;
        emit_word   = IDLE_WORD;
        emit_last   = 1'b0;
        emit_done   = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_head;
                    case (i_head.op)
                        CMD_START: begin
                            n_slot      = '0;
                            n_sync_sent = 1'b0;
                            n_cnt       = CNT_W'(PREAMBLE_WORDS - 1);
                            n_state     = BK_PRE;
                        end
                        CMD_MSG: begin
                            n_state = BK_CW;
                        end
                        CMD_END: begin
                            n_cnt   = CNT_W'(i_head.tail);
                            n_state = i_head.has_cw ? BK_CW : BK_TAIL;
                        end
                        default: begin
                            n_state = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_PRE: begin
                emit_valid = 1'b1;
                emit_word  = PREAMBLE_PATTERN;
                if (adv) begin
                    if (r_cnt == '0) begin
                        n_state = BK_PAD_S;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            BK_PAD_S, BK_CW, BK_TAIL, BK_PAD_E: begin
                emit_valid = 1'b1;
                if (is_sync) begin
                    // Batch boundary: the sync word goes ahead of the codeword.
                    emit_word = SYNC_WORD;
                    if (adv) begin
                        n_sync_sent = 1'b1;
                    end
                end else begin
                    if (adv) begin
                        n_slot      = slot_inc;
                        n_sync_sent = 1'b0;
                    end
                    case (r_state)
                        BK_PAD_S: begin
                            if (r_slot == r_cmd.target) begin
                                emit_word = info_cw;
                                emit_last = 1'b1;
                                if (adv) begin
                                    n_state = BK_IDLE;
                                end
                            end
                        end
                        BK_CW: begin
                            emit_word = info_cw;
                            if (r_cmd.op == CMD_END) begin
                                if (adv) begin
                                    n_state = BK_TAIL;
                                end
                            end else begin
                                emit_last = 1'b1;
                                if (adv) begin
                                    n_state = BK_IDLE;
                                end
                            end
                        end
                        BK_TAIL: begin
                            if (r_cnt == '0) begin
                                if (slot_inc == '0) begin
                                    emit_last = 1'b1;
                                    emit_done = 1'b1;
                                    if (adv) begin
                                        n_state = BK_IDLE;
                                    end
                                end else if (adv) begin
                                    n_state = BK_PAD_E;
                                end
                            end else if (adv) begin
                                n_cnt = r_cnt - 1'b1;
                            end
                        end
                        default: begin
                            // Idle fill up to the end of the batch.
                            if (slot_inc == '0) begin
                                emit_last = 1'b1;
                                emit_done = 1'b1;
                                if (adv) begin
                                    n_state = BK_IDLE;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_sync_sent <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_slot      <= n_slot;
            r_sync_sent <= n_sync_sent;
        end
    end

    // Command being expanded.
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= emit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_word <= emit_word;
            r_last <= emit_last;
            r_done <= emit_done;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_word              = r_word;
    assign o_last_of_run       = r_last;
    assign o_transmission_done = r_done;

endmodule

// ----- rtl/core/pocsag_chk.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pocsag_chk
// Port-level checks of the POCSAG paging encoder, bound to the top level.
// ============================================================================
module pocsag_chk import pocsag_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_word,
    input logic        o_last_of_run,
    input logic        o_transmission_done
);

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // The final word of a transmission also ends the run of its item.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_transmission_done |-> o_last_of_run)
        else $error("transmission done without last of run");

    // A transmission always closes with an idle codeword.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_transmission_done |-> o_word == IDLE_WORD)
        else $error("transmission closed by a non-idle word");

    // A stalled word is held.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_word)
            && $stable(o_last_of_run) && $stable(o_transmission_done))
        else $error("stalled output word changed");

endmodule

bind pocsag_paging_encoder pocsag_chk u_chk (.*);
